// ===== rtl/mccb_pkg.sv =====
package mccb_pkg;

  // Input command codes
  localparam logic [1:0] CMD_PARAM   = 2'd0;
  localparam logic [1:0] CMD_RETX    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Controllers covered by one retransmit mask group
  localparam int         GROUP_W     = 7;
  localparam logic [2:0] GROUP_LAST  = 3'(GROUP_W - 1);

  // Largest seven-bit controller value
  localparam logic [6:0] CC_MAX      = 7'd127;

  // Kind of work the sequencer is doing for the current item
  typedef enum logic [1:0] {
    OP_SWITCH = 2'd0,
    OP_RETX   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  // One candidate result handed to the output stage
  typedef struct packed {
    logic       vld;
    logic [3:0] channel;
    logic [5:0] controller;
    logic [6:0] value;
  } cand_t;

  // Quantize a 1.16 fraction to 0..127: floor(v * 128 / 65536), saturated
  function automatic logic [6:0] quant_cc(input logic [16:0] v);
    logic [6:0] q;
    if (v[16]) begin
      q = CC_MAX;
    end else begin
      q = v[15:9];
    end
    return q;
  endfunction

endpackage

// ===== rtl/mccb_ram.sv =====
module mccb_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write one entry, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/mccb_emit.sv =====
module mccb_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  mccb_pkg::cand_t cand,
  input  logic            flush,
  input  logic [15:0]     ts,
  output logic            out_valid,
  output logic [3:0]      out_channel,
  output logic [5:0]      out_controller,
  output logic [6:0]      out_cc_value,
  output logic [15:0]     out_sample_offset,
  output logic            out_last
);

  import mccb_pkg::*;

  logic        pend_vld_r;
  logic        pend_vld_nxt;
  cand_t       pend_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [3:0]  out_channel_r;
  logic [5:0]  out_controller_r;
  logic [6:0]  out_cc_value_r;
  logic [15:0] out_sample_offset_r;
  logic        out_last_r;

  // Hold one result back so the final beat of an item can carry last
  always_comb begin
    out_valid_nxt = pend_vld_r && (cand.vld || flush);
    pend_vld_nxt  = pend_vld_r;
    if (cand.vld) begin
      pend_vld_nxt = 1'b1;
    end else if (flush) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance payload into the pending slot and out to the ports
  always_ff @(posedge clk) begin
    if (cand.vld) begin
      pend_r <= cand;
    end
    if (out_valid_nxt) begin
      out_channel_r       <= pend_r.channel;
      out_controller_r    <= pend_r.controller;
      out_cc_value_r      <= pend_r.value;
      out_sample_offset_r <= ts;
      out_last_r          <= flush;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_controller    = out_controller_r;
  assign out_cc_value      = out_cc_value_r;
  assign out_sample_offset = out_sample_offset_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/midi_cc_bank_memory_core.sv =====
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+---------------------------
// input    | in_command, in_param_id, in_param_value,     | accepted when start & !busy
//          | in_mask_group, in_select_bits,               |
//          | in_sample_offset                             |
// result   | out_channel, out_controller, out_cc_value,   | one-cycle strobe out_valid,
//          | out_sample_offset, out_last                  | taken on that cycle
//
// Per item: a switch to another bank walks all NUM_CCS controllers, a controller write
// splits the id into bank and controller by repeated subtract, a retransmit steps
// through one mask group, and a clear walks the bank and then sweeps the table.
// The walks read one table entry (two on a bank switch) per cycle from the
// dual-read table RAM. After reset a clearing pass writes zero to all
// NUM_BANKS*NUM_CCS entries, one per cycle, with busy high. Results are registered,
// one held back so the final one can carry out_last; the receiver cannot stall.
module midi_cc_bank_memory_core #(
  parameter int NUM_BANKS     = 16,
  parameter int NUM_CCS       = 64,
  parameter int EXPOSED_COUNT = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_param_id,
  input  logic [16:0] in_param_value,
  input  logic [3:0]  in_mask_group,
  input  logic [6:0]  in_select_bits,
  input  logic [15:0] in_sample_offset,
  output logic        out_valid,
  output logic [3:0]  out_channel,
  output logic [5:0]  out_controller,
  output logic [6:0]  out_cc_value,
  output logic [15:0] out_sample_offset,
  output logic        out_last
);

  import mccb_pkg::*;

  localparam int         DEPTH     = NUM_BANKS * NUM_CCS;
  localparam int         AW        = $clog2(DEPTH);
  localparam logic [AW-1:0] CCS_A  = AW'(NUM_CCS);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic [5:0] CC_LAST   = 6'(NUM_CCS - 1);
  localparam logic [6:0] CCS_7     = 7'(NUM_CCS);
  localparam logic [5:0] BANK_MAX  = 6'(NUM_BANKS - 1);
  localparam logic [4:0] BANKS_5   = 5'(NUM_BANKS);
  localparam logic [10:0] EXP_11   = 11'(EXPOSED_COUNT);
  localparam logic [11:0] ID_END   = 12'(EXPOSED_COUNT + DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SWEEP = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_WRITE = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_RETX  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t        state_r,    state_nxt;
  op_t           op_r,       op_nxt;
  logic [3:0]    cur_r,      cur_nxt;
  logic [AW-1:0] base_cur_r, base_cur_nxt;
  logic [3:0]    nb_r,       nb_nxt;
  logic [AW-1:0] base_new_r, base_new_nxt;
  logic [5:0]    cc_r,       cc_nxt;
  logic [2:0]    k_r,        k_nxt;
  logic [AW-1:0] sweep_r,    sweep_nxt;
  logic [AW-1:0] rem_r,      rem_nxt;
  logic [3:0]    q_r,        q_nxt;
  logic [AW-1:0] off_r,      off_nxt;
  logic [6:0]    y_r,        y_nxt;
  logic [6:0]    grp7_r,     grp7_nxt;
  logic [6:0]    bits_r,     bits_nxt;
  logic [15:0]   ts_r,       ts_nxt;
  logic          rd_vld_r,   rd_vld_nxt;
  logic [5:0]    rd_cc_r;

  logic [21:0]   bank_prod;
  logic [3:0]    bank_q;
  logic [10:0]   id_off;
  logic [6:0]    retx_cc;
  logic          retx_sel;
  logic [5:0]    issue_cc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [6:0]    rdata_a;
  logic [6:0]    rdata_b;
  logic          flush;
  cand_t         cand;

  // Quantize the bank select: floor(v * NUM_BANKS / 65536), saturated
  assign bank_prod = 22'(in_param_value) * 22'(BANKS_5);
  assign bank_q    = (bank_prod[21:16] > BANK_MAX) ? BANK_MAX[3:0] : bank_prod[19:16];
  assign id_off    = in_param_id - EXP_11;

  // Controller of the current retransmit step and whether it is read
  assign retx_cc  = grp7_r + 7'(k_r);
  assign retx_sel = bits_r[k_r] && (retx_cc < CCS_7);
  assign issue_cc = (state_r == S_RETX) ? retx_cc[5:0] : cc_r;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cur_nxt      = cur_r;
    base_cur_nxt = base_cur_r;
    nb_nxt       = nb_r;
    base_new_nxt = base_new_r;
    cc_nxt       = cc_r;
    k_nxt        = k_r;
    sweep_nxt    = sweep_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    off_nxt      = off_r;
    y_nxt        = y_r;
    grp7_nxt     = grp7_r;
    bits_nxt     = bits_r;
    ts_nxt       = ts_r;
    rd_vld_nxt   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = sweep_r;
    ram_wdata    = '0;
    flush        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ts_nxt   = in_sample_offset;
          grp7_nxt = 7'(in_mask_group) * 7'(GROUP_W);
          bits_nxt = in_select_bits;
          cc_nxt   = '0;
          k_nxt    = '0;
          priority if (in_command == CMD_PARAM) begin
            if (in_param_id < EXP_11) begin
              nb_nxt       = bank_q;
              base_new_nxt = AW'(AW'(bank_q) * CCS_A);
              op_nxt       = OP_SWITCH;
              if (bank_q != cur_r) begin
                state_nxt = S_WALK;
              end
            end else if ({1'b0, in_param_id} < ID_END) begin
              rem_nxt   = AW'(id_off);
              off_nxt   = AW'(id_off);
              q_nxt     = '0;
              y_nxt     = quant_cc(in_param_value);
              op_nxt    = OP_WRITE;
              state_nxt = S_DIV;
            end
          end else if (in_command == CMD_RETX) begin
            op_nxt    = OP_RETX;
            state_nxt = S_RETX;
          end else if (in_command == CMD_CLEAR) begin
            op_nxt    = OP_CLEAR;
            state_nxt = S_WALK;
          end
        end
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        // Split the offset into bank and controller, one subtract per cycle
        if (rem_r >= CCS_A) begin
          rem_nxt = rem_r - CCS_A;
          q_nxt   = q_r + 1'b1;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = off_r;
        ram_wdata = y_r;
        state_nxt = S_FLUSH;
      end
      S_WALK: begin
        rd_vld_nxt = 1'b1;
        cc_nxt     = cc_r + 1'b1;
        if (cc_r == CC_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_RETX: begin
        rd_vld_nxt = retx_sel;
        k_nxt      = k_r + 1'b1;
        if (k_r == GROUP_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        flush = 1'b1;
        if (op_r == OP_SWITCH) begin
          cur_nxt      = nb_r;
          base_cur_nxt = base_new_r;
        end
        if (op_r == OP_CLEAR) begin
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      op_r       <= OP_SWITCH;
      cur_r      <= '0;
      base_cur_r <= '0;
      sweep_r    <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      cur_r      <= cur_nxt;
      base_cur_r <= base_cur_nxt;
      sweep_r    <= sweep_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
  end

  // Hold per-item payload
  always_ff @(posedge clk) begin
    nb_r       <= nb_nxt;
    base_new_r <= base_new_nxt;
    cc_r       <= cc_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    off_r      <= off_nxt;
    y_r        <= y_nxt;
    grp7_r     <= grp7_nxt;
    bits_r     <= bits_nxt;
    ts_r       <= ts_nxt;
    rd_cc_r    <= issue_cc;
  end

  // Table reads: port A current bank, port B new bank
  assign raddr_a = AW'(base_cur_r + AW'(issue_cc));
  assign raddr_b = AW'(base_new_r + AW'(cc_r));

  mccb_ram #(
    .WIDTH (7),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Decide whether the entry just read, or the write in progress, gives a result
  always_comb begin
    cand            = '0;
    cand.controller = rd_cc_r;
    cand.channel    = cur_r;
    cand.value      = rdata_a;
    if (state_r == S_WRITE) begin
      cand.vld        = (q_r == cur_r);
      cand.controller = 6'(rem_r);
      cand.value      = y_r;
    end else if (rd_vld_r) begin
      unique case (op_r)
        OP_SWITCH: begin
          cand.vld     = (rdata_a != rdata_b);
          cand.channel = nb_r;
          cand.value   = rdata_b;
        end
        OP_RETX: begin
          cand.vld = 1'b1;
        end
        OP_CLEAR: begin
          cand.vld   = (rdata_a != '0);
          cand.value = '0;
        end
        OP_WRITE: begin
          cand.vld = 1'b0;
        end
        default: begin
          cand.vld = 1'b0;
        end
      endcase
    end
  end

  mccb_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cand              (cand),
    .flush             (flush),
    .ts                (ts_r),
    .out_valid         (out_valid),
    .out_channel       (out_channel),
    .out_controller    (out_controller),
    .out_cc_value      (out_cc_value),
    .out_sample_offset (out_sample_offset),
    .out_last          (out_last)
  );

  assign busy = (state_r != S_IDLE);

endmodule
